### hw/rtl/vbtf_pkg.sv
// ----------------------------------------------------------------------------
// vbtf_pkg: shared types and constants for the video beam timing block
// Rate tables, field-rate selection, output mode codes and register indexes.
// ----------------------------------------------------------------------------
package vbtf_pkg;

   localparam int RAM_WORD_BITS       = 18;
   localparam int DECISION_COLUMN     = 1004;
   localparam int LENGTH_LATCH_COLUMN = 108;

   localparam int COL_BITS    = 10;
   localparam int LEN_BITS    = 11;
   localparam int LINE_BITS   = 9;
   localparam int VADDR_BITS  = 23;
   localparam int FADDR_BITS  = 18;
   localparam int PAGE_BITS   = 16;
   localparam int PAGE_SHIFT  = VADDR_BITS - PAGE_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // column, after the step, at which vertical sync changes
   localparam logic [LEN_BITS-1:0]  VSYNC_COLUMN     = LEN_BITS'(30 * 2);
   localparam logic [LINE_BITS-1:0] VSYNC_END_LINE   = LINE_BITS'(3);
   localparam logic [LEN_BITS+1-1:0] HSYNC_SET_LEAD  = (LEN_BITS + 1)'(50 * 2);
   localparam logic [LEN_BITS+1-1:0] HSYNC_CLR_LEAD  = (LEN_BITS + 1)'(10 * 2);
   localparam logic [LEN_BITS-1:0]  RESET_LINE_LENGTH = LEN_BITS'(1024);

   localparam logic [VADDR_BITS:0] RAM_MASK_WIDE =
      ((VADDR_BITS + 1)'(1) << RAM_WORD_BITS) - (VADDR_BITS + 1)'(1);
   localparam logic [VADDR_BITS-1:0] RAM_MASK = RAM_MASK_WIDE[VADDR_BITS-1:0];

   localparam logic [1:0] VIDEO_MODE_MONO = 2'd2;

   typedef enum logic [1:0] {
      RATE_50 = 2'd0,
      RATE_60 = 2'd1,
      RATE_72 = 2'd2
   } rate_type;

   typedef enum logic [1:0] {
      MODE_SYNC   = 2'd0,
      MODE_BLANK  = 2'd1,
      MODE_BORDER = 2'd2,
      MODE_PIXELS = 2'd3
   } output_mode_type;

   typedef enum logic [1:0] {
      SCHED_NONE  = 2'd0,
      SCHED_BEGIN = 2'd1,
      SCHED_END   = 2'd2
   } schedule_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASE_PAGE  = 2'd0,
      CSR_VIDEO_MODE = 2'd1,
      CSR_SYNC_FIFTY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic         enable;
      logic         sync;
      schedule_type schedule;
   } vert_flags_type;

   function automatic rate_type rate_select(input logic [1:0] video_mode,
                                            input logic fifty);
      rate_type r;
      if (video_mode == VIDEO_MODE_MONO) r = RATE_72;
      else if (fifty) r = RATE_50;
      else r = RATE_60;
      return r;
   endfunction

   function automatic logic [LEN_BITS-1:0] h_set_en(input rate_type r);
      case (r)
         RATE_50: return LEN_BITS'(56 * 2);
         RATE_60: return LEN_BITS'(52 * 2);
         default: return LEN_BITS'(4 * 2);
      endcase
   endfunction

   function automatic logic [LEN_BITS-1:0] h_reset_en(input rate_type r);
      case (r)
         RATE_50: return LEN_BITS'(376 * 2);
         RATE_60: return LEN_BITS'(372 * 2);
         default: return LEN_BITS'(164 * 2);
      endcase
   endfunction

   function automatic logic [LEN_BITS-1:0] h_set_bl(input rate_type r);
      case (r)
         RATE_50: return LEN_BITS'(450 * 2);
         RATE_60: return LEN_BITS'(450 * 2);
         default: return LEN_BITS'(184 * 2);
      endcase
   endfunction

   function automatic logic [LEN_BITS-1:0] h_reset_bl(input rate_type r);
      case (r)
         RATE_50: return LEN_BITS'(28 * 2);
         RATE_60: return LEN_BITS'(24 * 2);
         default: return LEN_BITS'(2 * 2);
      endcase
   endfunction

   function automatic logic [LEN_BITS-1:0] h_length(input rate_type r);
      case (r)
         RATE_50: return LEN_BITS'(512 * 2);
         RATE_60: return LEN_BITS'(508 * 2);
         default: return LEN_BITS'(224 * 2);
      endcase
   endfunction

   function automatic logic [LINE_BITS-1:0] v_set_en(input rate_type r);
      case (r)
         RATE_50: return LINE_BITS'(63);
         RATE_60: return LINE_BITS'(34);
         default: return LINE_BITS'(1);
      endcase
   endfunction

   function automatic logic [LINE_BITS-1:0] v_reset_en(input rate_type r);
      case (r)
         RATE_50: return LINE_BITS'(263);
         RATE_60: return LINE_BITS'(234);
         default: return LINE_BITS'(401);
      endcase
   endfunction

   function automatic logic [LINE_BITS-1:0] v_height(input rate_type r);
      case (r)
         RATE_50: return LINE_BITS'(313);
         RATE_60: return LINE_BITS'(263);
         default: return LINE_BITS'(500);
      endcase
   endfunction

endpackage

### hw/rtl/video_beam_timing_and_fetch.sv
// ----------------------------------------------------------------------------
// video_beam_timing_and_fetch: raster beam timing and video word fetch
// Advances the beam one half-cycle per tick, tracks sync/enable/blank flags
// and issues video memory word fetches while pixels are shown.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_tick
//  rsp     | out       | rsp_valid / rsp_stall | sync, enable, mode, fetch, position
//  csr     | in        | csr_write             | csr_index, csr_data
//
//  one transaction per clock while req_stall is low; its result appears in the output register on the next cycle
//  the beam state updates in the same edge that accepts the tick
//  req_stall is high only while a held result is stalled, so a new tick is taken
//  in the cycle the previous result leaves
//  synchronous reset loads line length 1024 and clears the beam, flags, fetch counter, valid and config registers
// ----------------------------------------------------------------------------
module video_beam_timing_and_fetch (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_tick,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hsync_out,
   output logic                                 rsp_vsync_out,
   output logic                                 rsp_display_enabled,
   output logic [1:0]                           rsp_output_mode,
   output logic                                 rsp_fetch_valid,
   output logic [vbtf_pkg::FADDR_BITS-1:0]      rsp_fetch_address,
   output logic                                 rsp_group_complete,
   output logic [vbtf_pkg::COL_BITS-1:0]        rsp_beam_column,
   output logic [vbtf_pkg::LINE_BITS-1:0]       rsp_beam_line,
   input  logic                                 csr_write,
   input  logic [vbtf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [vbtf_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import vbtf_pkg::*;

   // configuration
   logic [PAGE_BITS-1:0]  base_page_ff;
   logic [1:0]            video_mode_ff;
   logic                  sync_fifty_ff;

   // beam state
   logic [COL_BITS-1:0]   column_ff,      column_in;
   logic [LINE_BITS-1:0]  line_ff,        line_in;
   logic [LINE_BITS-1:0]  next_line_ff,   next_line_in;
   logic [LEN_BITS-1:0]   line_length_ff, line_length_in;
   logic                  h_blank_ff,     h_blank_in;
   logic                  h_enable_ff,    h_enable_in;
   logic                  h_sync_ff,      h_sync_in;
   vert_flags_type        vert_ff,        vert_in;
   vert_flags_type        next_vert_ff,   next_vert_in;
   logic [VADDR_BITS-1:0] vaddr_ff,       vaddr_in;
   logic [1:0]            fetch_slot_ff,  fetch_slot_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  hsync_ff, vsync_ff, enabled_ff;
   output_mode_type       mode_ff;
   logic                  fetch_ff, group_ff;
   logic [FADDR_BITS-1:0] faddr_ff;
   logic [COL_BITS-1:0]   rsp_col_ff;
   logic [LINE_BITS-1:0]  rsp_line_ff;

   logic                  accept;
   logic                  step;
   rate_type              rate;
   output_mode_type       mode;
   logic                  fetch;
   logic                  group;
   logic [FADDR_BITS-1:0] faddr;
   logic [LEN_BITS-1:0]   col_inc;
   logic [LEN_BITS:0]     col_wide;
   logic [VADDR_BITS-1:0] vaddr_masked;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign step      = accept & req_tick;
   assign rate      = rate_select(video_mode_ff, sync_fifty_ff);
   assign col_inc   = LEN_BITS'(column_ff) + LEN_BITS'(1);
   assign col_wide  = {1'b0, col_inc};
   assign vaddr_masked = vaddr_ff & RAM_MASK;

   always_comb begin
      if (h_sync_ff || vert_ff.sync) mode = MODE_SYNC;
      else if (h_blank_ff) mode = MODE_BLANK;
      else if (!vert_ff.enable) mode = MODE_BORDER;
      else if (h_enable_ff) mode = MODE_PIXELS;
      else mode = MODE_BORDER;
   end

   always_comb begin
      column_in      = column_ff;
      line_in        = line_ff;
      next_line_in   = next_line_ff;
      line_length_in = line_length_ff;
      h_blank_in     = h_blank_ff;
      h_enable_in    = h_enable_ff;
      h_sync_in      = h_sync_ff;
      vert_in        = vert_ff;
      next_vert_in   = next_vert_ff;
      vaddr_in       = vaddr_ff;
      fetch_slot_in  = fetch_slot_ff;
      fetch          = 1'b0;
      group          = 1'b0;
      faddr          = '0;

      if (step) begin
         if (mode == MODE_BLANK) begin
            fetch_slot_in = '0;
         end else if (mode == MODE_PIXELS && column_ff[2:0] == 3'b111) begin
            fetch         = 1'b1;
            faddr         = vaddr_masked[FADDR_BITS-1:0];
            vaddr_in      = vaddr_ff + VADDR_BITS'(1);
            fetch_slot_in = fetch_slot_ff + 2'd1;
            group         = (fetch_slot_in == 2'd0);
         end

         if (column_ff == COL_BITS'(LENGTH_LATCH_COLUMN)) line_length_in = h_length(rate);

         // next line's vertical state is settled here and applied at end of line
         if (column_ff == COL_BITS'(DECISION_COLUMN)) begin
            next_line_in          = line_ff + LINE_BITS'(1);
            next_vert_in          = vert_ff;
            next_vert_in.schedule = SCHED_NONE;
            if (next_line_in == v_set_en(rate)) begin
               next_vert_in.enable = 1'b1;
            end else if (next_line_in == v_reset_en(rate)) begin
               next_vert_in.enable = 1'b0;
            end else if (next_line_in == v_height(rate)) begin
               next_line_in          = '0;
               next_vert_in.schedule = SCHED_BEGIN;
               vaddr_in              = {base_page_ff, PAGE_SHIFT'(0)};
            end else if (next_line_in == VSYNC_END_LINE) begin
               next_vert_in.schedule = SCHED_END;
            end
         end

         if (col_inc == h_reset_bl(rate)) h_blank_in = 1'b0;
         else if (col_inc == h_set_bl(rate)) h_blank_in = 1'b1;
         else if (col_inc == h_reset_en(rate)) h_enable_in = 1'b0;
         else if (col_inc == h_set_en(rate)) h_enable_in = 1'b1;
         else if (col_wide + HSYNC_SET_LEAD == {1'b0, line_length_ff}) h_sync_in = 1'b1;
         else if (col_wide + HSYNC_CLR_LEAD == {1'b0, line_length_ff}) h_sync_in = 1'b0;

         if (vert_ff.schedule != SCHED_NONE && col_inc == VSYNC_COLUMN) begin
            vert_in.sync = (vert_ff.schedule == SCHED_BEGIN);
            if (vert_ff.schedule == SCHED_BEGIN) vert_in.enable = 1'b0;
         end

         if (col_inc == line_length_ff) begin
            column_in = '0;
            vert_in   = next_vert_in;
            line_in   = next_line_in;
         end else begin
            column_in = col_inc[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_page_ff  <= '0;
         video_mode_ff <= '0;
         sync_fifty_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BASE_PAGE:  base_page_ff  <= csr_data[PAGE_BITS-1:0];
            CSR_VIDEO_MODE: video_mode_ff <= csr_data[1:0];
            CSR_SYNC_FIFTY: sync_fifty_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= '0;
         line_ff        <= '0;
         next_line_ff   <= '0;
         line_length_ff <= RESET_LINE_LENGTH;
         h_blank_ff     <= 1'b0;
         h_enable_ff    <= 1'b0;
         h_sync_ff      <= 1'b0;
         vert_ff        <= '{enable: 1'b0, sync: 1'b0, schedule: SCHED_NONE};
         next_vert_ff   <= '{enable: 1'b0, sync: 1'b0, schedule: SCHED_NONE};
         vaddr_ff       <= '0;
         fetch_slot_ff  <= '0;
      end else begin
         column_ff      <= column_in;
         line_ff        <= line_in;
         next_line_ff   <= next_line_in;
         line_length_ff <= line_length_in;
         h_blank_ff     <= h_blank_in;
         h_enable_ff    <= h_enable_in;
         h_sync_ff      <= h_sync_in;
         vert_ff        <= vert_in;
         next_vert_ff   <= next_vert_in;
         vaddr_ff       <= vaddr_in;
         fetch_slot_ff  <= fetch_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, loaded with each accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         hsync_ff    <= h_sync_in;
         vsync_ff    <= vert_in.sync;
         enabled_ff  <= h_enable_in & vert_in.enable;
         mode_ff     <= mode;
         fetch_ff    <= fetch;
         faddr_ff    <= faddr;
         group_ff    <= group;
         rsp_col_ff  <= column_in;
         rsp_line_ff <= line_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hsync_out       = hsync_ff;
   assign rsp_vsync_out       = vsync_ff;
   assign rsp_display_enabled = enabled_ff;
   assign rsp_output_mode     = mode_ff;
   assign rsp_fetch_valid     = fetch_ff;
   assign rsp_fetch_address   = faddr_ff;
   assign rsp_group_complete  = group_ff;
   assign rsp_beam_column     = rsp_col_ff;
   assign rsp_beam_line       = rsp_line_ff;

   // a fetch only happens on the last half-cycle of an 8-wide window while showing pixels
   a_fetch_in_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && fetch_ff |-> mode_ff == MODE_PIXELS && rsp_col_ff[2:0] == 3'b000)
      else $error("fetch outside pixel window");

   a_no_fetch_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !fetch_ff |-> !group_ff && faddr_ff == '0)
      else $error("group or address without fetch");

   a_length_legal: assert property (@(posedge clock) disable iff (reset)
      line_length_ff == RESET_LINE_LENGTH || line_length_ff == h_length(RATE_60) ||
      line_length_ff == h_length(RATE_72))
      else $error("latched line length not from rate table");

   a_column_in_line: assert property (@(posedge clock) disable iff (reset)
      LEN_BITS'(column_ff) < line_length_ff)
      else $error("beam column beyond line length");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tick |=> $stable(column_ff) && $stable(line_ff) && $stable(vaddr_ff))
      else $error("beam moved on an empty tick");

endmodule
